>>> sv/bra_pkg.sv
// Shared types, constants and mask helpers of the bitmap range allocator.
`timescale 1ns / 1ps
`default_nettype none
package bra_pkg;

  // Bitmap geometry
  localparam int MAP_BITS  = 1024;
  localparam int WORD_BITS = 64;
  localparam int WORDS     = MAP_BITS / WORD_BITS;
  localparam int WIDX_W    = $clog2(WORD_BITS);
  localparam int WADDR_W   = $clog2(WORDS);

  // Field widths
  localparam int OP_W    = 2;
  localparam int SIZE_W  = 11;
  localparam int START_W = 11;
  localparam int LEN_W   = 11;
  localparam int ALIGN_W = 10;
  localparam int POS_W   = 12;

  localparam logic [SIZE_W-1:0] MAP_SIZE_RESET = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_SET    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL_INIT,
    ST_FILL,
    ST_SRCH_INIT,
    ST_FREE,
    ST_ALN0,
    ST_ALN1,
    ST_ALN2,
    ST_ALN3,
    ST_CHK,
    ST_USED,
    ST_RETRY,
    ST_RESP
  } state_e;

  typedef struct packed {
    op_e                op;
    logic [START_W-1:0] range_start;
    logic [LEN_W-1:0]   range_length;
    logic [ALIGN_W-1:0] aln_mask;
    logic [ALIGN_W-1:0] aln_off;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0] found_index;
    logic             no_room;
  } res_t;

  typedef struct packed {
    logic                 we;
    logic [WADDR_W-1:0]   addr;
    logic [WORD_BITS-1:0] data;
  } wr_t;

  typedef struct packed {
    logic [POS_W-1:0] from;
    logic [POS_W-1:0] limit;
    logic             want;
  } scan_req_t;

  typedef struct packed {
    logic             hit;
    logic             last;
    logic [POS_W-1:0] pos;
  } scan_res_t;

  // Bits of word w at or above bit position from
  function automatic logic [WORD_BITS-1:0] from_mask(input logic [WADDR_W-1:0] w,
                                                      input logic [POS_W-1:0] from);
    logic [POS_W-WIDX_W-1:0] fw;
    logic [WORD_BITS-1:0]    ones;
    fw   = from[POS_W-1:WIDX_W];
    ones = '1;
    if (fw == (POS_W-WIDX_W)'(w)) begin
      from_mask = ones << from[WIDX_W-1:0];
    end else if (fw < (POS_W-WIDX_W)'(w)) begin
      from_mask = ones;
    end else begin
      from_mask = '0;
    end
  endfunction

  // Bits of word w below bit position limit
  function automatic logic [WORD_BITS-1:0] lim_mask(input logic [WADDR_W-1:0] w,
                                                     input logic [POS_W-1:0] limit);
    logic [POS_W-WIDX_W-1:0] lw;
    logic [WORD_BITS-1:0]    ones;
    lw   = limit[POS_W-1:WIDX_W];
    ones = '1;
    if (lw > (POS_W-WIDX_W)'(w)) begin
      lim_mask = ones;
    end else if (lw == (POS_W-WIDX_W)'(w)) begin
      lim_mask = ~(ones << limit[WIDX_W-1:0]);
    end else begin
      lim_mask = '0;
    end
  endfunction

endpackage
`default_nettype wire

>>> sv/bra_bitmap.sv
// Allocation bitmap: word array cleared at reset, one read-modify-write port.
`timescale 1ns / 1ps
`default_nettype none
module bra_bitmap (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bra_pkg::wr_t                  wr_i,
  input  logic [bra_pkg::WADDR_W-1:0]   rd_addr_i,
  output logic [bra_pkg::WORD_BITS-1:0] rd_data_o
);
  import bra_pkg::*;

  logic [WORD_BITS-1:0] mem_q [WORDS];

  // Word storage, all bits free after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WORDS; i++) begin
        mem_q[i] <= '0;
      end
    end else if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  assign rd_data_o = mem_q[rd_addr_i];

endmodule
`default_nettype wire

>>> sv/bra_word_scan.sv
// Shared word scan unit: first bit of a wanted value inside a bit window.
`timescale 1ns / 1ps
`default_nettype none
module bra_word_scan (
  input  logic [bra_pkg::WORD_BITS-1:0] word_i,
  input  logic [bra_pkg::WADDR_W-1:0]   word_addr_i,
  input  bra_pkg::scan_req_t            req_i,
  output bra_pkg::scan_res_t            res_o
);
  import bra_pkg::*;

  logic [WORD_BITS-1:0] cand;
  logic [WIDX_W-1:0]    ffs;
  logic [WADDR_W:0]     wnext;

  // Candidate bits: wanted value inside [from, limit)
  assign cand = (req_i.want ? word_i : ~word_i)
              & from_mask(word_addr_i, req_i.from)
              & lim_mask(word_addr_i, req_i.limit);

  // Lowest candidate bit
  always_comb begin
    ffs = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        ffs = WIDX_W'(i);
      end
    end
  end

  // This word reaches the limit
  assign wnext = {1'b0, word_addr_i} + (WADDR_W+1)'(1);

  assign res_o.hit  = |cand;
  assign res_o.last = POS_W'({wnext, {WIDX_W{1'b0}}}) >= req_i.limit;
  assign res_o.pos  = POS_W'({word_addr_i, ffs});

endmodule
`default_nettype wire

>>> sv/bra_seq.sv
// Request sequencer: fill, free-run search, alignment and retry over a shared adder.
`timescale 1ns / 1ps
`default_nettype none
module bra_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bra_pkg::req_t                 req_i,
  input  logic [bra_pkg::SIZE_W-1:0]    map_size_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output bra_pkg::res_t                 res_o,
  output logic [bra_pkg::WADDR_W-1:0]   rd_addr_o,
  input  logic [bra_pkg::WORD_BITS-1:0] rd_data_i,
  output bra_pkg::wr_t                  wr_o,
  output bra_pkg::scan_req_t            scan_o,
  input  bra_pkg::scan_res_t            scan_i
);
  import bra_pkg::*;

  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  logic [POS_W-1:0]     start_q, start_d;
  logic [LEN_W-1:0]     len_q, len_d;
  logic [ALIGN_W-1:0]   amask_q, amask_d;
  logic [ALIGN_W-1:0]   aoff_q, aoff_d;
  logic [SIZE_W-1:0]    size_q, size_d;
  logic [POS_W-1:0]     t_q, t_d;       // candidate, aligned value or used bit
  logic [POS_W-1:0]     idx_q, idx_d;
  logic [POS_W-1:0]     end_q, end_d;
  logic [WADDR_W-1:0]   word_q, word_d;
  res_t                 res_q, res_d;

  logic [POS_W-1:0]     add_a, add_b, add_sum;
  logic                 add_sub;
  logic [POS_W-1:0]     fill_end;
  logic [POS_W-1:0]     size_pos;
  logic [WADDR_W:0]     wnext;
  logic                 fill_last;
  logic [WORD_BITS-1:0] fill_mask;

  assign size_pos = POS_W'(size_q);

  // Shared adder operand select
  always_comb begin
    add_a   = t_q;
    add_b   = '0;
    add_sub = 1'b0;
    case (state_q)
      ST_FILL_INIT: begin
        add_a = start_q;
        add_b = POS_W'(len_q);
      end
      ST_ALN0: add_b = POS_W'(aoff_q);
      ST_ALN1: add_b = POS_W'(amask_q);
      ST_ALN2: begin
        add_b   = POS_W'(aoff_q);
        add_sub = 1'b1;
      end
      ST_ALN3: begin
        add_a = idx_q;
        add_b = POS_W'(len_q);
      end
      ST_RETRY: add_b = POS_W'(1);
      default: ;
    endcase
  end

  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + POS_W'(add_sub);

  // Fill range end clipped to the map, and last-word detect
  assign fill_end  = (add_sum > POS_W'(MAP_BITS)) ? POS_W'(MAP_BITS) : add_sum;
  assign wnext     = {1'b0, word_q} + (WADDR_W+1)'(1);
  assign fill_last = POS_W'({wnext, {WIDX_W{1'b0}}}) >= end_q;
  assign fill_mask = from_mask(word_q, start_q) & lim_mask(word_q, end_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (req_i.op)
            OP_SET, OP_CLEAR: state_d = ST_FILL_INIT;
            OP_SEARCH:        state_d = ST_SRCH_INIT;
            default:          state_d = ST_RESP;
          endcase
        end
      end
      ST_FILL_INIT: state_d = (start_q < fill_end) ? ST_FILL : ST_RESP;
      ST_FILL:      if (fill_last) state_d = ST_RESP;
      ST_SRCH_INIT: state_d = (start_q >= size_pos) ? ST_ALN0 : ST_FREE;
      ST_FREE:      if (scan_i.hit || scan_i.last) state_d = ST_ALN0;
      ST_ALN0:      state_d = ST_ALN1;
      ST_ALN1:      state_d = ST_ALN2;
      ST_ALN2:      state_d = ST_ALN3;
      ST_ALN3:      state_d = ST_CHK;
      ST_CHK: begin
        if (end_q > size_pos || idx_q >= end_q) state_d = ST_RESP;
        else                                    state_d = ST_USED;
      end
      ST_USED: begin
        if (scan_i.hit)       state_d = ST_RETRY;
        else if (scan_i.last) state_d = ST_RESP;
      end
      ST_RETRY:     state_d = ST_SRCH_INIT;
      ST_RESP:      if (res_ready_i) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Datapath register updates
  always_comb begin
    op_d    = op_q;
    start_d = start_q;
    len_d   = len_q;
    amask_d = amask_q;
    aoff_d  = aoff_q;
    size_d  = size_q;
    t_d     = t_q;
    idx_d   = idx_q;
    end_d   = end_q;
    word_d  = word_q;
    res_d   = res_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = req_i.op;
          start_d = POS_W'(req_i.range_start);
          len_d   = req_i.range_length;
          amask_d = req_i.aln_mask;
          aoff_d  = req_i.aln_off;
          size_d  = (map_size_i > SIZE_W'(MAP_BITS)) ? SIZE_W'(MAP_BITS) : map_size_i;
          res_d   = '0;
        end
      end
      ST_FILL_INIT: begin
        end_d  = fill_end;
        word_d = start_q[WIDX_W +: WADDR_W];
      end
      ST_FILL:      word_d = word_q + WADDR_W'(1);
      ST_SRCH_INIT: begin
        word_d = start_q[WIDX_W +: WADDR_W];
        t_d    = size_pos;
      end
      ST_FREE: begin
        if (scan_i.hit) t_d = scan_i.pos;
        else            t_d = size_pos;
        word_d = word_q + WADDR_W'(1);
      end
      ST_ALN0:  t_d   = add_sum;
      ST_ALN1:  t_d   = add_sum & ~POS_W'(amask_q);
      ST_ALN2:  idx_d = add_sum;
      ST_ALN3:  end_d = add_sum;
      ST_CHK: begin
        if (end_q > size_pos) res_d = '{found_index: end_q, no_room: 1'b1};
        else                  res_d = '{found_index: idx_q, no_room: 1'b0};
        word_d = idx_q[WIDX_W +: WADDR_W];
      end
      ST_USED: begin
        t_d    = scan_i.pos;
        word_d = word_q + WADDR_W'(1);
      end
      ST_RETRY: start_d = add_sum;
      default: ;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    res_valid_o = (state_q == ST_RESP);
    res_o       = res_q;
    rd_addr_o   = word_q;
    wr_o.we     = (state_q == ST_FILL);
    wr_o.addr   = word_q;
    wr_o.data   = (op_q == OP_SET) ? (rd_data_i | fill_mask) : (rd_data_i & ~fill_mask);
    scan_o.want = (state_q == ST_USED);
    scan_o.from = (state_q == ST_USED) ? idx_q : start_q;
    scan_o.limit = (state_q == ST_USED) ? end_q : size_pos;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    start_q <= start_d;
    len_q   <= len_d;
    amask_q <= amask_d;
    aoff_q  <= aoff_d;
    size_q  <= size_d;
    t_q     <= t_d;
    idx_q   <= idx_d;
    end_q   <= end_d;
    word_q  <= word_d;
    res_q   <= res_d;
  end

`ifndef SYNTH
  a_no_room_past_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && res_q.no_room) |-> (res_q.found_index > size_pos))
    else $error("no room reported for a run end inside the map");

  a_found_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && op_q == OP_SEARCH && !res_q.no_room)
      |-> (end_q <= size_pos && res_q.found_index == idx_q))
    else $error("found run does not fit the map");

  a_retry_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RETRY) |=> (start_q > $past(start_q)))
    else $error("search retry did not move forward");

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.we |-> (POS_W'({word_q, {WIDX_W{1'b0}}}) < end_q))
    else $error("fill write beyond range end");

  a_used_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_USED) |-> (idx_q < end_q && end_q <= size_pos))
    else $error("used-bit scan over an empty or oversized window");
`endif

endmodule
`default_nettype wire

>>> sv/bitmap_range_allocator_top.sv
// Top level of the bitmap range allocator: stream ports, map size register, result register.
//
// Requests arrive on the s_axis channel (op in tuser, range fields in tdata) and one
// result per request leaves on m_axis (found index in tdata, no-room flag in tuser).
// The map size register is written through cfg_valid_i / cfg_data_i, always ready.
// One request is worked on at a time; s_axis_tready is high only while the sequencer
// idles. The bitmap is scanned one 64-bit word per cycle by a shared scan unit.
// Set / clear: after acceptance, a setup step, then one read-modify-write per word touched,
// then the result. Search: each pass runs a setup step, a scan for a free bit, the align
// steps and a check, a scan for a used bit inside the run and a retry step.
// A pass ends at a used bit inside the candidate run, so the search time grows with
// fragmentation; the result then passes through the result register to m_axis.
// The result register parts the two sides: a stalled receiver holds the result and
// the next request is taken meanwhile; its own result waits in the sequencer.
// Reset clears the whole bitmap at once (every bit free), sets map size to 1024 and
// empties the result register.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_range_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request: tdata = range_start[10:0], range_length[21:11], aln_mask[31:22],
  //          aln_off[41:32], zero fill to 48
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  // Result: tdata = found_index[11:0], zero fill to 16
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,
  output logic [0:0]  m_axis_tuser,  // no_room[0]
  // Map size write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i
);
  import bra_pkg::*;

  req_t                 req;
  res_t                 res;
  res_t                 out_q, out_d;
  logic                 out_valid_q, out_valid_d;
  logic                 res_valid, res_ready;
  logic [SIZE_W-1:0]    map_size_q;
  logic [WADDR_W-1:0]   rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  wr_t                  wr;
  scan_req_t            scan_req;
  scan_res_t            scan_res;

  // Request unpack
  assign req.op           = op_e'(s_axis_tuser);
  assign req.range_start  = s_axis_tdata[10:0];
  assign req.range_length = s_axis_tdata[21:11];
  assign req.aln_mask     = s_axis_tdata[31:22];
  assign req.aln_off      = s_axis_tdata[41:32];

  // Map size register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_size_q <= MAP_SIZE_RESET;
    end else if (cfg_valid_i) begin
      map_size_q <= cfg_data_i;
    end
  end

  bra_bitmap u_bitmap (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  bra_word_scan u_scan (
    .word_i      (rd_data),
    .word_addr_i (rd_addr),
    .req_i       (scan_req),
    .res_o       (scan_res)
  );

  bra_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_i       (req),
    .map_size_i  (map_size_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_o        (wr),
    .scan_o      (scan_req),
    .scan_i      (scan_res)
  );

  // Result register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_q.found_index};
  assign m_axis_tuser  = out_q.no_room;

endmodule
`default_nettype wire

>>> verif/bitmap_range_allocator_top_tb.sv
// Self-checking testbench for the bitmap range allocator top level.
`timescale 1ns / 1ps
module bitmap_range_allocator_top_tb;
  import bra_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // range_start, range_length, aln_mask, aln_off, zero fill
  logic [1:0]  s_axis_tuser;   // op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // found_index, zero fill
  logic [0:0]  m_axis_tuser;   // no_room
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [10:0] cfg_data_i;

  bitmap_range_allocator_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Shadow copy of the bitmap and the map size register
  bit          used_map [0:MAP_BITS-1];
  logic [10:0] map_size_sh;

  // Answers predicted for accepted requests, oldest first
  res_t pending_answers [$];

  // Live allocations made by the traffic generator
  int alloc_start [$];
  int alloc_len   [$];

  int err_cnt;
  bit gaps_on;
  int hold_req_cnt;
  int hold_seen;
  int hold_left;
  int sink_gap;

  // Clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Global watchdog
  initial begin
    #(60_000_000);
    $display("bitmap_range_allocator_top regression: fail");
    $finish;
  end

  // First bit in [from, limit) equal to want, else limit
  function automatic longint unsigned first_bit(longint unsigned limit,
                                                longint unsigned from, bit want);
    longint unsigned b;
    for (b = from; b < limit; b++) begin
      if (used_map[b[9:0]] == want) return b;
    end
    return limit;
  endfunction

  // Mark [start, start + len) clipped to the map
  function automatic void fill_bits(longint unsigned start, longint unsigned len, bit v);
    longint unsigned stop;
    longint unsigned b;
    stop = start + len;
    if (stop > 64'(MAP_BITS)) stop = 64'(MAP_BITS);
    for (b = start; b < stop; b++) used_map[b[9:0]] = v;
  endfunction

  // Aligned free run search with retry past each used bit
  function automatic res_t find_free_run(longint unsigned start, longint unsigned nr,
                                         longint unsigned amask, longint unsigned aoff);
    res_t            r;
    longint unsigned size;
    longint unsigned from;
    longint unsigned idx;
    longint unsigned fin;
    longint unsigned used;
    r    = '0;
    size = (map_size_sh > 11'(MAP_BITS)) ? 64'(MAP_BITS) : 64'(map_size_sh);
    from = start;
    while (1) begin
      idx = first_bit(size, from, 1'b0);
      idx = ((idx + aoff + amask) & ~amask) - aoff;
      fin = idx + nr;
      if (fin > size) begin
        r.found_index = fin[POS_W-1:0];
        r.no_room     = 1'b1;
        return r;
      end
      used = first_bit(fin, idx, 1'b1);
      if (used < fin) begin
        from = used + 64'd1;
      end else begin
        r.found_index = idx[POS_W-1:0];
        return r;
      end
    end
  endfunction

  // Apply one request to the shadow state and return its answer
  function automatic res_t model_request(op_e op, logic [10:0] start, logic [10:0] len,
                                         logic [9:0] amask, logic [9:0] aoff);
    res_t r;
    r = '0;
    case (op)
      OP_SET:    fill_bits(64'(start), 64'(len), 1'b1);
      OP_CLEAR:  fill_bits(64'(start), 64'(len), 1'b0);
      OP_SEARCH: r = find_free_run(64'(start), 64'(len), 64'(amask), 64'(aoff));
      default:   ;
    endcase
    return r;
  endfunction

  // Sink ready: long hold-offs on request, random stall bursts otherwise while gaps are on
  always @(posedge clk_i) begin
    if (hold_seen != hold_req_cnt) begin
      hold_seen = hold_req_cnt;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      sink_gap = $urandom_range(0, 5);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result transaction against the oldest prediction
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_answers.size() == 0) begin
        if (err_cnt < 10) $display("unexpected result: index %0d no_room %0b",
                                   m_axis_tdata[POS_W-1:0], m_axis_tuser[0]);
        err_cnt++;
      end else begin
        want = pending_answers.pop_front();
        if (m_axis_tdata[POS_W-1:0] !== want.found_index || m_axis_tuser[0] !== want.no_room)
        begin
          if (err_cnt < 10) $display("mismatch: index exp %0d got %0d, no_room exp %0b got %0b",
                                     want.found_index, m_axis_tdata[POS_W-1:0],
                                     want.no_room, m_axis_tuser[0]);
          err_cnt++;
        end
      end
    end
  end

  // One request transaction; the predicted answer is returned to the caller
  task automatic send_req(input op_e op, input logic [10:0] start, input logic [10:0] len,
                          input logic [9:0] amask, input logic [9:0] aoff, output res_t r);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, aoff, amask, len, start};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = model_request(op, start, len, amask, aoff);
    pending_answers.push_back(r);
  endtask

  task automatic stop_req();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Map size write, only with the block idle
  task automatic write_map_size(input logic [10:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    map_size_sh = v;
  endtask

  // Set and clear ranges at the map edges, clipping and zero lengths, with searches between
  task automatic test_fill_edges();
    res_t r;
    send_req(OP_SET,    11'd0,    11'd0,    10'd0, 10'd0, r);
    send_req(OP_SET,    11'd0,    11'd1,    10'd0, 10'd0, r);
    send_req(OP_SET,    11'd1020, 11'd1024, 10'd0, 10'd0, r);
    send_req(OP_SET,    11'd1024, 11'd5,    10'd0, 10'd0, r);
    send_req(OP_SET,    11'd2047, 11'd2047, 10'd0, 10'd0, r);
    send_req(OP_SEARCH, 11'd1000, 11'd30,   10'd0, 10'd0, r);
    send_req(OP_CLEAR,  11'd0,    11'd2047, 10'd0, 10'd0, r);
    send_req(OP_SET,    11'd100,  11'd64,   10'd0, 10'd0, r);
    send_req(OP_SEARCH, 11'd0,    11'd10,   10'd0, 10'd0, r);
    send_req(OP_SEARCH, 11'd90,   11'd20,   10'd0, 10'd0, r);
    send_req(OP_CLEAR,  11'd0,    11'd1024, 10'd0, 10'd0, r);
    stop_req();
  endtask

  // Search corner cases: zero length, start past size, odd masks, unused op
  task automatic test_search_cases();
    res_t r;
    send_req(OP_SET,    11'd1,    11'd1,    10'd0,    10'd0,    r);
    send_req(OP_SEARCH, 11'd0,    11'd0,    10'd0,    10'd0,    r);
    send_req(OP_SEARCH, 11'd1023, 11'd0,    10'd0,    10'd0,    r);
    send_req(OP_SEARCH, 11'd1024, 11'd0,    10'd0,    10'd0,    r);
    send_req(OP_SEARCH, 11'd2047, 11'd1,    10'd0,    10'd0,    r);
    send_req(OP_SEARCH, 11'd0,    11'd8,    10'd7,    10'd0,    r);
    send_req(OP_SEARCH, 11'd0,    11'd4,    10'd5,    10'd3,    r);
    send_req(OP_SEARCH, 11'd0,    11'd1,    10'd1023, 10'd1023, r);
    send_req(OP_SEARCH, 11'd0,    11'd1024, 10'd1023, 10'd0,    r);
    send_req(OP_SEARCH, 11'd0,    11'd2047, 10'd0,    10'd0,    r);
    send_req(OP_NONE,   11'd2047, 11'd2047, 10'd1023, 10'd1023, r);
    send_req(OP_CLEAR,  11'd0,    11'd2,    10'd0,    10'd0,    r);
    stop_req();
  endtask

  // Map size extremes: zero, one, above the map, back to full
  task automatic test_map_size();
    res_t r;
    write_map_size(11'd0);
    send_req(OP_SEARCH, 11'd0,    11'd1,  10'd0, 10'd0, r);
    send_req(OP_SEARCH, 11'd0,    11'd0,  10'd0, 10'd0, r);
    stop_req();
    write_map_size(11'd1);
    send_req(OP_SEARCH, 11'd0,    11'd1,  10'd0, 10'd0, r);
    send_req(OP_SEARCH, 11'd0,    11'd2,  10'd0, 10'd0, r);
    stop_req();
    write_map_size(11'd2047);
    send_req(OP_SEARCH, 11'd1000, 11'd24, 10'd0, 10'd0, r);
    send_req(OP_SEARCH, 11'd1000, 11'd25, 10'd0, 10'd0, r);
    stop_req();
    write_map_size(11'd1024);
  endtask

  // Allocator-like traffic: search then claim, frees, and random noise
  task automatic alloc_traffic(input int n);
    res_t        r;
    int          sel;
    int          k;
    logic [10:0] start;
    logic [10:0] len;
    logic [9:0]  amask;
    logic [9:0]  aoff;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        case ($urandom_range(0, 9))
          0:       len = 11'd0;
          1:       len = 11'($urandom_range(0, 2047));
          2:       len = 11'($urandom_range(25, 200));
          default: len = 11'($urandom_range(1, 24));
        endcase
        case ($urandom_range(0, 5))
          0:       amask = 10'd0;
          1:       amask = 10'd1;
          2:       amask = 10'd3;
          3:       amask = 10'd7;
          4:       amask = 10'd63;
          default: amask = 10'($urandom_range(0, 1023));
        endcase
        case ($urandom_range(0, 3))
          0:       aoff = 10'($urandom_range(0, 1023));
          1:       aoff = 10'($urandom_range(0, 7));
          default: aoff = 10'd0;
        endcase
        case ($urandom_range(0, 7))
          0:       start = 11'($urandom_range(0, 2047));
          1, 2:    start = 11'($urandom_range(0, 1023));
          default: start = 11'd0;
        endcase
        send_req(OP_SEARCH, start, len, amask, aoff, r);
        if (r.no_room) begin
          if ($urandom_range(0, 1) == 0) begin
            send_req(OP_CLEAR, 11'd0, 11'd1024, 10'd0, 10'd0, r);
            alloc_start.delete();
            alloc_len.delete();
          end
        end else if (len != 0) begin
          send_req(OP_SET, r.found_index[10:0], len, 10'd0, 10'd0, r);
          alloc_start.push_back(int'(r.found_index));
          alloc_len.push_back(int'(len));
        end
      end else if (sel < 68 && alloc_start.size() != 0) begin
        k = $urandom_range(0, alloc_start.size() - 1);
        send_req(OP_CLEAR, 11'(alloc_start[k]), 11'(alloc_len[k]),
                 10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)), r);
        alloc_start.delete(k);
        alloc_len.delete(k);
      end else if (sel < 71) begin
        send_req(OP_CLEAR, 11'd0, 11'd2047, 10'd0, 10'd0, r);
        alloc_start.delete();
        alloc_len.delete();
      end else begin
        // Noise: any op with any field values
        send_req(op_e'(2'($urandom_range(0, 3))), 11'($urandom_range(0, 2047)),
                 11'($urandom_range(0, 2047)), 10'($urandom_range(0, 1023)),
                 10'($urandom_range(0, 1023)), r);
      end
    end
    stop_req();
  endtask

  // Several map sizes, idling toggled per phase
  task automatic test_random();
    write_map_size(11'd1024);
    gaps_on = 1'b1;
    alloc_traffic(180);
    write_map_size(11'($urandom_range(64, 1023)));
    gaps_on = 1'b0;
    alloc_traffic(150);
    write_map_size(11'd2047);
    gaps_on = 1'b1;
    alloc_traffic(150);
    write_map_size(11'd1);
    alloc_traffic(20);
    write_map_size(11'd0);
    alloc_traffic(20);
    write_map_size(11'($urandom_range(2, 1023)));
    alloc_traffic(150);
    write_map_size(11'($urandom_range(1025, 2046)));
    alloc_traffic(150);
    write_map_size(11'd1024);
  endtask

  // Sink holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_req_cnt++;
    alloc_traffic(16);
  endtask

  // Closing stretch without any idling
  task automatic test_tail();
    gaps_on = 1'b0;
    alloc_traffic(80);
  endtask

  // Test sequence
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    err_cnt       = 0;
    gaps_on       = 1'b1;
    hold_req_cnt  = 0;
    hold_seen     = 0;
    hold_left     = 0;
    sink_gap      = 0;
    map_size_sh   = MAP_SIZE_RESET;
    foreach (used_map[i]) used_map[i] = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_edges();
    test_search_cases();
    test_map_size();
    test_random();
    test_backpressure();
    test_tail();

    drain();
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0 && pending_answers.size() == 0) begin
      $display("bitmap_range_allocator_top regression: pass");
    end else begin
      $display("bitmap_range_allocator_top regression: fail");
    end
    $finish;
  end

endmodule
